@@ rtl/core/rmf_pkg.sv @@
// Shared constants and types for the running median filter.
`timescale 1ns / 1ps

package rmf_pkg;

    localparam int WINDOW   = 15;
    localparam int SAMPLE_W = 16;
    localparam int AGE_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MID      = WINDOW / 2;

    // What one cell shows its neighbors: its value, its age and whether
    // the value is at or below the sample now being inserted.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] val;
        logic [AGE_W-1:0]           age;
        logic                       le;
    } t_link;

endpackage

@@ rtl/core/running_median_filter.sv @@
// Top level of the running median filter: a sorted chain of sample cells.
`timescale 1ns / 1ps

// The filter keeps the last WINDOW samples (15) in ascending order in a row
// of cells and, for every accepted item, returns the sample at sorted rank
// WINDOW/2 of the updated window. After reset the window holds WINDOW zeros,
// and those zeros count as samples, so the first outputs lean toward zero.
// For every item the whole chain updates at the edge where the
// item is accepted, and its median appears on o_median with o_valid in the
// next cycle. A new item is accepted in each cycle in which the output
// register is empty or is being emptied, so the sustained rate is one item
// per clock; the limit is the single output register.
module running_median_filter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [rmf_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [rmf_pkg::SAMPLE_W-1:0]  o_median
);

    // links[k] is what cell k shows; the chain ends see a value below
    // everything on the left and above everything on the right, so the
    // end cells never take from beyond the chain.
    rmf_pkg::t_link links [rmf_pkg::WINDOW];
    logic [rmf_pkg::WINDOW:0] gone;
    rmf_pkg::t_link left_end;
    rmf_pkg::t_link right_end;

    logic shift;
    logic r_valid;

    assign left_end  = '{val: '0, age: '0, le: 1'b1};
    assign right_end = '{val: '0, age: '0, le: 1'b0};

    assign o_ready = !r_valid || i_ready;
    assign shift   = i_valid && o_ready;
    assign gone[0] = 1'b0;

    // Cell k starts with age k so that the reset zeros leave in a fixed
    // order; gone[k] says that the oldest entry sits in a cell below k.
    for (genvar k = 0; k < rmf_pkg::WINDOW; k++) begin : g_cell
        rmf_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_shift        (shift),
            .i_sample       (i_sample),
            .i_init_age     (rmf_pkg::AGE_W'(k)),
            .i_left         ((k == 0) ? left_end : links[(k == 0) ? 0 : k - 1]),
            .i_right        ((k == rmf_pkg::WINDOW - 1) ? right_end
                             : links[(k == rmf_pkg::WINDOW - 1) ? k : k + 1]),
            .i_gone_below   (gone[k]),
            .o_link         (links[k]),
            .o_gone_through (gone[k + 1])
        );
    end

    // The middle cell holds the median once the chain has moved, so the
    // output register only carries the valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (shift) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid  = r_valid;
    assign o_median = links[rmf_pkg::MID].val;

endmodule

@@ rtl/core/rmf_cell.sv @@
// One cell of the sorted chain: holds one sample and its age in the window.
`timescale 1ns / 1ps

module rmf_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_shift,
    input  logic signed [rmf_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [rmf_pkg::AGE_W-1:0]            i_init_age,
    input  rmf_pkg::t_link                       i_left,
    input  rmf_pkg::t_link                       i_right,
    input  logic                                 i_gone_below,
    output rmf_pkg::t_link                       o_link,
    output logic                                 o_gone_through
);

    typedef enum logic [1:0] {
        SRC_OWN,
        SRC_LEFT,
        SRC_RIGHT,
        SRC_NEW
    } t_src;

    logic signed [rmf_pkg::SAMPLE_W-1:0] r_val, n_val;
    logic [rmf_pkg::AGE_W-1:0]           r_age, n_age;
    logic                                own_le;
    logic                                own_old;
    t_src                                src;

    assign own_le         = (r_val <= i_sample);
    assign own_old        = (r_age == rmf_pkg::AGE_W'(rmf_pkg::WINDOW - 1));
    assign o_link         = '{val: r_val, age: r_age, le: own_le};
    assign o_gone_through = i_gone_below | own_old;

    // The oldest entry leaves the list and the new sample goes in at its
    // sorted place; each cell picks from itself, a neighbor or the sample.
    always_comb begin
        if (i_gone_below) begin
            src = i_right.le ? SRC_RIGHT : (own_le ? SRC_NEW : SRC_OWN);
        end else if (own_old) begin
            src = i_right.le ? SRC_RIGHT : (i_left.le ? SRC_NEW : SRC_LEFT);
        end else begin
            src = own_le ? SRC_OWN : (i_left.le ? SRC_NEW : SRC_LEFT);
        end

        case (src)
            SRC_OWN: begin
                n_val = r_val;
                n_age = r_age + 1'b1;
            end
            SRC_LEFT: begin
                n_val = i_left.val;
                n_age = i_left.age + 1'b1;
            end
            SRC_RIGHT: begin
                n_val = i_right.val;
                n_age = i_right.age + 1'b1;
            end
            default: begin
                n_val = i_sample;
                n_age = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
            r_age <= i_init_age;
        end else if (i_shift) begin
            r_val <= n_val;
            r_age <= n_age;
        end
    end

endmodule
